/* hdl/vme_pkg.sv */
// Shared types, codes and reset constants for the vibration motor envelope block.
`timescale 1ns / 1ps

package vme_pkg;

    // Default width of the millisecond time counters.
    localparam int TIME_BITS_DEF = 32;

    // Configuration port geometry.
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 48;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_ENV_LENGTH = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ENV_ATTACK = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ENV_DECAY  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LEVELS     = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GAINS      = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OSC_PERIOD = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_OSC_COUNT  = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_OSC_WINDOW = 4'd7;

    // Register reset values.
    localparam logic [24:0] LEVELS_RESET = 25'd4784128;
    localparam logic [23:0] GAINS_RESET  = 24'd65535;
    localparam logic [15:0] PERIOD_RESET = 16'hFFFF;

    // Motor phase codes.
    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_ACTIVE  = 2'd1;
    localparam logic [1:0] PH_BRAKE   = 2'd2;
    localparam logic [1:0] PH_RELEASE = 2'd3;

    // Widths of the serial arithmetic unit.
    localparam int ARITH_A_W = 24;
    localparam int ARITH_B_W = 16;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TICK,
        ST_CHECK,
        ST_CLASS,
        ST_RMUL,
        ST_RDIV,
        ST_EMUL,
        ST_XMUL,
        ST_MIX,
        ST_WMUL,
        ST_WDIV,
        ST_FIN,
        ST_GMUL,
        ST_DONE
    } vme_state_t;

    // Operations of the serial arithmetic unit.
    typedef enum logic {
        OP_MUL,
        OP_DIV
    } vme_op_t;

    // Control into the arithmetic unit.
    typedef struct packed {
        logic    start;
        vme_op_t op;
    } arith_ctl_t;

    // Status out of the arithmetic unit.
    typedef struct packed {
        logic busy;
        logic done;
    } arith_stat_t;

endpackage

/* hdl/vme_arith.sv */
// Bit-serial multiplier and divider shared by the envelope sequencer.
`timescale 1ns / 1ps

module vme_arith (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  vme_pkg::arith_ctl_t                 ctl,
    input  logic [vme_pkg::ARITH_A_W-1:0]       opa,    // multiplicand (15:0) or dividend
    input  logic [vme_pkg::ARITH_B_W-1:0]       opb,    // multiplier (7:0) or divisor
    output vme_pkg::arith_stat_t                stat,
    output logic [vme_pkg::ARITH_A_W-1:0]       result
);

    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    vme_pkg::vme_op_t op_reg, op_next;
    logic [2:0]      cnt_reg, cnt_next;
    logic [23:0]     acc_reg, acc_next;
    logic [22:0]     sh_reg, sh_next;
    logic [7:0]      mb_reg, mb_next;
    logic            ge;

    // One multiplier bit or one quotient bit per cycle, most significant first.
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        op_next   = op_reg;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        sh_next   = sh_reg;
        mb_next   = mb_reg;
        ge        = acc_reg >= {1'b0, sh_reg};
        if (ctl.start) begin
            busy_next = 1'b1;
            op_next   = ctl.op;
            cnt_next  = 3'd7;
            if (ctl.op == vme_pkg::OP_MUL) begin
                acc_next = '0;
                sh_next  = {7'd0, opa[15:0]};
                mb_next  = opb[7:0];
            end else begin
                acc_next = opa;
                sh_next  = {opb, 7'd0};
                mb_next  = '0;
            end
        end else if (busy_reg) begin
            if (op_reg == vme_pkg::OP_MUL) begin
                acc_next = {acc_reg[22:0], 1'b0} + (mb_reg[7] ? {8'd0, sh_reg[15:0]} : 24'd0);
                mb_next  = {mb_reg[6:0], 1'b0};
            end else begin
                if (ge) begin
                    acc_next = acc_reg - {1'b0, sh_reg};
                end
                mb_next = {mb_reg[6:0], ge};
                sh_next = {1'b0, sh_reg[22:1]};
            end
            cnt_next = cnt_reg - 3'd1;
            if (cnt_reg == 3'd0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        op_reg  <= op_next;
        cnt_reg <= cnt_next;
        acc_reg <= acc_next;
        sh_reg  <= sh_next;
        mb_reg  <= mb_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign result    = (op_reg == vme_pkg::OP_MUL) ? acc_reg : {16'd0, mb_reg};

endmodule

/* hdl/vibration_motor_envelope.sv */
// Top level of the vibration motor envelope generator.
`timescale 1ns / 1ps

// Each transaction on the input is either a one millisecond tick or a train
// trigger, and yields exactly one result transaction with the held PWM duty,
// the brake pin, the mixed envelope level and the motor phase. A trigger goes
// straight to the result; a tick skips the arithmetic when the motor is idle
// and the last level is zero. Otherwise every multiplication and division
// runs through one shared bit-serial unit at one bit per cycle, and a tick
// needs up to seven of them (ramp product and quotient, envelope gain,
// external gain, window product and quotient, master gain). One transaction
// is worked on at a time; a finished result waits in the output register
// while the next transaction is taken.
module vibration_motor_envelope #(
    parameter int TIME_BITS = vme_pkg::TIME_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Input stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,   // ext_drive 7:0
    input  logic [0:0]                       s_tuser,   // func 0
    // Result stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [23:0]                      m_tdata,   // drive_duty 7:0, brake_on 8,
                                                        // envelope_level 16:9, phase 18:17
    // Configuration writes
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [vme_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [vme_pkg::CFG_DATA_W-1:0]   cfg_data
);

    vme_pkg::vme_state_t state_reg, state_next;
    logic launched_reg, launched_next;

    // Configuration registers
    logic [15:0] len_reg, att_reg, dec_reg, per_reg, ocnt_reg;
    logic [24:0] lvl_reg;
    logic [23:0] gain_reg;
    logic [47:0] win_reg;

    // Envelope state
    logic [TIME_BITS-1:0] now_reg, now_next;
    logic [TIME_BITS-1:0] onset_reg, onset_next;
    logic [TIME_BITS-1:0] tonset_reg, tonset_next;
    logic [15:0] ndone_reg, ndone_next;
    logic [1:0]  phase_reg, phase_next;
    logic        train_reg, train_next;
    logic [7:0]  last_reg, last_next;
    logic [7:0]  duty_reg, duty_next;
    logic        brake_reg, brake_next;

    // Work registers
    logic [7:0]  ext_reg, ext_next;
    logic [7:0]  v_reg, v_next;
    logic [7:0]  es_reg, es_next;
    logic [15:0] n_reg, n_next;
    logic [15:0] d_reg, d_next;
    logic [7:0]  start_reg, start_next;
    logic [7:0]  diff_reg, diff_next;
    logic        fall_reg, fall_next;
    logic [23:0] prod_reg, prod_next;

    // Output register
    logic        mv_reg, mv_next;
    logic [23:0] md_reg, md_next;

    // Arithmetic unit
    vme_pkg::arith_ctl_t  actl;
    vme_pkg::arith_stat_t astat;
    logic [23:0] opa, ares;
    logic [15:0] opb;

    // Field views
    logic [7:0]  amp, base, brk, lo, master, eg, xg;
    logic        expm;
    logic [15:0] dec_c, tl, oa, od;
    logic [TIME_BITS-1:0] now_inc, cur0, cur, ocur;
    logic [32:0] cur_x, ocur_x, lb_x;
    logic        in_acc, out_free, arith_state;
    logic [8:0]  mix_sum;

    assign amp    = lvl_reg[7:0];
    assign base   = lvl_reg[15:8];
    assign brk    = lvl_reg[23:16];
    assign expm   = lvl_reg[24];
    assign lo     = expm ? base : 8'd0;
    assign master = gain_reg[7:0];
    assign eg     = gain_reg[15:8];
    assign xg     = gain_reg[23:16];
    assign tl     = win_reg[15:0];
    assign oa     = win_reg[31:16];
    assign od     = win_reg[47:32];
    assign dec_c  = (dec_reg > len_reg) ? len_reg : dec_reg;

    assign now_inc = now_reg + 1'b1;
    assign cur0    = now_inc - onset_reg;
    assign cur     = now_reg - onset_reg;
    assign ocur    = now_reg - tonset_reg;
    assign cur_x   = 33'(cur);
    assign ocur_x  = 33'(ocur);
    assign lb_x    = 33'(len_reg) + 33'(brk);
    assign mix_sum = {1'b0, es_reg} + {1'b0, ares[15:8]};

    assign in_acc   = s_tvalid && s_tready;
    assign out_free = !mv_reg || m_tready;
    assign arith_state = (state_reg == vme_pkg::ST_RMUL) || (state_reg == vme_pkg::ST_RDIV) ||
                         (state_reg == vme_pkg::ST_EMUL) || (state_reg == vme_pkg::ST_XMUL) ||
                         (state_reg == vme_pkg::ST_WMUL) || (state_reg == vme_pkg::ST_WDIV) ||
                         (state_reg == vme_pkg::ST_GMUL);

    vme_arith u_arith (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (actl),
        .opa     (opa),
        .opb     (opb),
        .stat    (astat),
        .result  (ares)
    );

    // Next state of the sequencer.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            vme_pkg::ST_IDLE: begin
                if (in_acc) begin
                    state_next = s_tuser[0] ? vme_pkg::ST_DONE : vme_pkg::ST_TICK;
                end
            end
            vme_pkg::ST_TICK:  state_next = vme_pkg::ST_CHECK;
            vme_pkg::ST_CHECK: begin
                if (phase_reg == vme_pkg::PH_IDLE && last_reg == 8'd0) begin
                    state_next = vme_pkg::ST_DONE;
                end else begin
                    state_next = vme_pkg::ST_CLASS;
                end
            end
            vme_pkg::ST_CLASS: begin
                state_next = vme_pkg::ST_EMUL;
                if (phase_reg != vme_pkg::PH_IDLE && !(cur_x > lb_x)) begin
                    if (cur_x < 33'(att_reg)) begin
                        state_next = vme_pkg::ST_RMUL;
                    end else if (cur_x >= 33'(len_reg - dec_c) && cur_x < 33'(len_reg)) begin
                        state_next = vme_pkg::ST_RMUL;
                    end
                end
            end
            vme_pkg::ST_RMUL: if (astat.done) state_next = vme_pkg::ST_RDIV;
            vme_pkg::ST_RDIV: if (astat.done) state_next = vme_pkg::ST_EMUL;
            vme_pkg::ST_EMUL: if (astat.done) state_next = vme_pkg::ST_XMUL;
            vme_pkg::ST_XMUL: if (astat.done) state_next = vme_pkg::ST_MIX;
            vme_pkg::ST_MIX: begin
                state_next = vme_pkg::ST_FIN;
                if (ocnt_reg > 16'd2) begin
                    if (ocur_x < 33'(oa)) begin
                        state_next = vme_pkg::ST_WMUL;
                    end else if (34'(ocur) + 34'(od) > 34'(tl) && od != 16'd0) begin
                        state_next = vme_pkg::ST_WMUL;
                    end
                end
            end
            vme_pkg::ST_WMUL: if (astat.done) state_next = vme_pkg::ST_WDIV;
            vme_pkg::ST_WDIV: if (astat.done) state_next = vme_pkg::ST_FIN;
            vme_pkg::ST_FIN: begin
                if (phase_reg == vme_pkg::PH_ACTIVE && master != 8'd255) begin
                    state_next = vme_pkg::ST_GMUL;
                end else begin
                    state_next = vme_pkg::ST_DONE;
                end
            end
            vme_pkg::ST_GMUL: if (astat.done) state_next = vme_pkg::ST_DONE;
            vme_pkg::ST_DONE: if (out_free) state_next = vme_pkg::ST_IDLE;
            default: state_next = vme_pkg::ST_IDLE;
        endcase
    end

    // Handshake and arithmetic unit control for each state.
    always_comb begin
        s_tready      = (state_reg == vme_pkg::ST_IDLE);
        actl.start    = arith_state && !launched_reg;
        actl.op       = vme_pkg::OP_MUL;
        launched_next = arith_state && !astat.done;
        opa           = '0;
        opb           = '0;
        case (state_reg)
            vme_pkg::ST_RMUL: begin
                opa = {8'd0, n_reg};
                opb = {8'd0, diff_reg};
            end
            vme_pkg::ST_RDIV: begin
                actl.op = vme_pkg::OP_DIV;
                opa     = fall_reg ? prod_reg + {8'd0, d_reg} - 24'd1 : prod_reg;
                opb     = d_reg;
            end
            vme_pkg::ST_EMUL: begin
                opa = {16'd0, eg};
                opb = {8'd0, v_reg};
            end
            vme_pkg::ST_XMUL: begin
                opa = {16'd0, ext_reg};
                opb = {8'd0, xg};
            end
            vme_pkg::ST_WMUL: begin
                opa = {8'd0, n_reg};
                opb = {8'd0, v_reg};
            end
            vme_pkg::ST_WDIV: begin
                actl.op = vme_pkg::OP_DIV;
                opa     = prod_reg;
                opb     = d_reg;
            end
            vme_pkg::ST_GMUL: begin
                opa = {16'd0, v_reg};
                opb = {8'd0, master};
            end
            default: begin
                opa = '0;
                opb = '0;
            end
        endcase
    end

    // Envelope state and work register updates.
    always_comb begin
        now_next    = now_reg;
        onset_next  = onset_reg;
        tonset_next = tonset_reg;
        ndone_next  = ndone_reg;
        phase_next  = phase_reg;
        train_next  = train_reg;
        last_next   = last_reg;
        duty_next   = duty_reg;
        brake_next  = brake_reg;
        ext_next    = ext_reg;
        v_next      = v_reg;
        es_next     = es_reg;
        n_next      = n_reg;
        d_next      = d_reg;
        start_next  = start_reg;
        diff_next   = diff_reg;
        fall_next   = fall_reg;
        prod_next   = prod_reg;
        mv_next     = mv_reg && !m_tready;
        md_next     = md_reg;
        case (state_reg)
            vme_pkg::ST_IDLE: begin
                if (in_acc) begin
                    ext_next = s_tdata;
                    // A trigger restarts the train at the current time, not advancing it.
                    if (s_tuser[0]) begin
                        if (ocnt_reg > ndone_reg) begin
                            if (!train_reg) onset_next = now_reg;
                            train_next = 1'b1;
                        end else begin
                            onset_next = now_reg;
                        end
                        phase_next  = vme_pkg::PH_ACTIVE;
                        ndone_next  = '0;
                        tonset_next = now_reg;
                    end
                end
            end
            vme_pkg::ST_TICK: begin
                // Advance time; restart the envelope each period, up to the train count.
                now_next = now_inc;
                if (ndone_reg < ocnt_reg && 33'(cur0) >= 33'(per_reg)) begin
                    phase_next = vme_pkg::PH_ACTIVE;
                    onset_next = now_inc;
                    ndone_next = ndone_reg + 16'd1;
                end
            end
            vme_pkg::ST_CHECK: begin
                // The external gain wakes the motor only when the drive is recomputed.
                if (xg != 8'd0 && !(phase_reg == vme_pkg::PH_IDLE && last_reg == 8'd0)) begin
                    phase_next = vme_pkg::PH_ACTIVE;
                end
            end
            vme_pkg::ST_CLASS: begin
                // Work out which part of the envelope the current time falls in.
                v_next = 8'd0;
                if (phase_reg != vme_pkg::PH_IDLE) begin
                    if (cur_x > lb_x) begin
                        if (!expm) begin
                            phase_next = vme_pkg::PH_RELEASE;
                        end else begin
                            v_next = base;
                        end
                    end else if (cur_x < 33'(att_reg)) begin
                        n_next     = cur[15:0];
                        d_next     = att_reg;
                        start_next = lo;
                        fall_next  = amp < lo;
                        diff_next  = (amp < lo) ? lo - amp : amp - lo;
                    end else if (cur_x < 33'(len_reg - dec_c)) begin
                        v_next = amp;
                    end else if (cur_x < 33'(len_reg)) begin
                        n_next     = cur[15:0] + dec_c - len_reg;
                        d_next     = dec_c;
                        start_next = amp;
                        fall_next  = lo < amp;
                        diff_next  = (lo < amp) ? amp - lo : lo - amp;
                    end else if (cur_x < lb_x) begin
                        if (!expm) begin
                            phase_next = vme_pkg::PH_BRAKE;
                        end else begin
                            v_next = base;
                        end
                    end
                end
            end
            vme_pkg::ST_RMUL: if (astat.done) prod_next = ares;
            vme_pkg::ST_RDIV: begin
                if (astat.done) begin
                    v_next = fall_reg ? start_reg - ares[7:0] : start_reg + ares[7:0];
                end
            end
            vme_pkg::ST_EMUL: if (astat.done) es_next = ares[15:8];
            vme_pkg::ST_XMUL: begin
                // Mix in the scaled external drive and saturate.
                if (astat.done) v_next = mix_sum[8] ? 8'd255 : mix_sum[7:0];
            end
            vme_pkg::ST_MIX: begin
                // Outer attack and decay window over the train.
                if (ocur_x < 33'(oa)) begin
                    n_next = ocur[15:0];
                    d_next = oa;
                end else begin
                    n_next = (33'(tl) > ocur_x) ? tl - ocur[15:0] : 16'd0;
                    d_next = od;
                end
            end
            vme_pkg::ST_WMUL: if (astat.done) prod_next = ares;
            vme_pkg::ST_WDIV: if (astat.done) v_next = ares[7:0];
            vme_pkg::ST_FIN: begin
                last_next = v_reg;
                case (phase_reg)
                    vme_pkg::PH_ACTIVE: begin
                        duty_next  = v_reg;
                        brake_next = 1'b0;
                    end
                    vme_pkg::PH_BRAKE: begin
                        duty_next  = 8'd0;
                        brake_next = 1'b1;
                    end
                    vme_pkg::PH_RELEASE: begin
                        duty_next  = 8'd0;
                        brake_next = 1'b0;
                        phase_next = vme_pkg::PH_IDLE;
                    end
                    default: begin
                        duty_next = duty_reg;
                    end
                endcase
            end
            vme_pkg::ST_GMUL: if (astat.done) duty_next = ares[15:8];
            vme_pkg::ST_DONE: begin
                if (out_free) begin
                    mv_next = 1'b1;
                    md_next = {5'd0, phase_reg, last_reg, brake_reg, duty_reg};
                end
            end
            default: begin
                v_next = v_reg;
            end
        endcase
    end

    // Configuration writes.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg  <= '0;
            att_reg  <= '0;
            dec_reg  <= '0;
            lvl_reg  <= vme_pkg::LEVELS_RESET;
            gain_reg <= vme_pkg::GAINS_RESET;
            per_reg  <= vme_pkg::PERIOD_RESET;
            ocnt_reg <= '0;
            win_reg  <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                vme_pkg::REG_ENV_LENGTH: len_reg  <= cfg_data[15:0];
                vme_pkg::REG_ENV_ATTACK: att_reg  <= cfg_data[15:0];
                vme_pkg::REG_ENV_DECAY:  dec_reg  <= cfg_data[15:0];
                vme_pkg::REG_LEVELS:     lvl_reg  <= cfg_data[24:0];
                vme_pkg::REG_GAINS:      gain_reg <= cfg_data[23:0];
                vme_pkg::REG_OSC_PERIOD: per_reg  <= cfg_data[15:0];
                vme_pkg::REG_OSC_COUNT:  ocnt_reg <= cfg_data[15:0];
                vme_pkg::REG_OSC_WINDOW: win_reg  <= cfg_data[47:0];
                default: len_reg <= len_reg;
            endcase
        end
    end

    // Control and envelope state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= vme_pkg::ST_IDLE;
            launched_reg <= 1'b0;
            now_reg      <= '0;
            onset_reg    <= '0;
            tonset_reg   <= '0;
            ndone_reg    <= '0;
            phase_reg    <= vme_pkg::PH_IDLE;
            train_reg    <= 1'b0;
            last_reg     <= '0;
            duty_reg     <= '0;
            brake_reg    <= 1'b0;
            mv_reg       <= 1'b0;
        end else begin
            state_reg    <= state_next;
            launched_reg <= launched_next;
            now_reg      <= now_next;
            onset_reg    <= onset_next;
            tonset_reg   <= tonset_next;
            ndone_reg    <= ndone_next;
            phase_reg    <= phase_next;
            train_reg    <= train_next;
            last_reg     <= last_next;
            duty_reg     <= duty_next;
            brake_reg    <= brake_next;
            mv_reg       <= mv_next;
        end
        ext_reg   <= ext_next;
        v_reg     <= v_next;
        es_reg    <= es_next;
        n_reg     <= n_next;
        d_reg     <= d_next;
        start_reg <= start_next;
        diff_reg  <= diff_next;
        fall_reg  <= fall_next;
        prod_reg  <= prod_next;
        md_reg    <= md_next;
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = md_reg;

endmodule

/* hdl/vme_checker.sv */
// Port-level checks for the vibration motor envelope block, bound to the top level.
`timescale 1ns / 1ps

module vme_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    // A stalled result transaction keeps its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Release always returns to idle before a result is shown.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[18:17] != 2'd3)
        else $error("release phase reported");

    // The brake is never driven together with a nonzero duty.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[8] |-> m_tdata[7:0] == 8'd0)
        else $error("brake with nonzero duty");

    // One transaction is in work at a time.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while busy");

endmodule

bind vibration_motor_envelope vme_checker u_vme_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
